// ===== hw/rtl/lcavg_pkg.sv =====
package lcavg_pkg;

  localparam int SampleW   = 24;
  localparam int NetW      = 25;
  localparam int CountW    = 8;
  localparam int SumW      = 32;
  localparam int MagW      = 31;
  localparam int LeftW     = 3;
  localparam int NibW      = 4;
  localparam int DataBytes = 6;
  localparam int DivSteps  = MagW;
  localparam int StepCntW  = 5;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_DONE
  } state_t;

  typedef enum logic {
    CFG_AVERAGE_COUNT = 1'b0,
    CFG_ZERO_OFFSET   = 1'b1
  } cfg_idx_t;

  typedef struct packed {
    logic accept;
    logic div_load;
    logic div_step;
    logic out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic mean_due;
  } dp_status_t;

  // data bits sit on the even positions of a double-rate byte
  function automatic logic [NibW-1:0] nibble_of(input logic [7:0] b);
    return {b[6], b[4], b[2], b[0]};
  endfunction

endpackage

// ===== hw/rtl/lcavg_ctrl.sv =====
module lcavg_ctrl (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  output logic                   out_valid,
  input  logic                   out_ready,
  input  lcavg_pkg::dp_status_t  status,
  output lcavg_pkg::ctrl_cmd_t   cmd
);
  import lcavg_pkg::*;

  state_t                state_r, state_nxt;
  logic [StepCntW-1:0]   step_r, step_nxt;
  logic                  out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
        if (in_valid && status.mean_due) begin
          cmd.div_load = 1'b1;
          step_nxt     = '0;
          state_nxt    = ST_DIV;
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (step_r == StepCntW'(DivSteps - 1)) begin
          state_nxt = ST_DONE;
        end else begin
          step_nxt = step_r + 1'b1;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  assign out_valid = out_valid_r;

endmodule

// ===== hw/rtl/lcavg_dp.sv =====
module lcavg_dp (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  lcavg_pkg::cfg_idx_t                cfg_index,
  input  logic [lcavg_pkg::SampleW-1:0]      cfg_wdata,
  input  logic                               in_mode,
  input  logic [7:0]                         in_rx_byte,
  input  lcavg_pkg::ctrl_cmd_t               cmd,
  output lcavg_pkg::dp_status_t              status,
  output logic signed [lcavg_pkg::SampleW-1:0] out_average_raw,
  output logic signed [lcavg_pkg::NetW-1:0]    out_net_value
);
  import lcavg_pkg::*;

  logic [CountW-1:0]         avg_count_r;
  logic [SampleW-1:0]        offset_r;
  logic [SampleW-1:0]        shift_r;
  logic [LeftW-1:0]          left_r;
  logic [CountW-1:0]         done_r;
  logic [SumW-1:0]           sum_r;

  logic                      neg_r;
  logic [MagW-1:0]           dq_r;
  logic [CountW-1:0]         rem_r;
  logic [CountW-1:0]         div_n_r;
  logic [SampleW-1:0]        avg_r;
  logic [NetW-1:0]           net_r;

  logic [SampleW-1:0]        shift_new;
  logic                      is_probe;
  logic                      reading_done;
  logic [SumW-1:0]           reading;
  logic [SumW-1:0]           sum_add;
  logic [SumW-1:0]           sum_mag;
  logic [CountW-1:0]         n;
  logic [CountW-1:0]         target;
  logic                      mean_due;
  logic [CountW+1:0]         trial;
  logic                      fits;
  logic [SampleW-1:0]        quo;
  logic [SampleW-1:0]        mean;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      avg_count_r <= CountW'(1);
      offset_r    <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_AVERAGE_COUNT: avg_count_r <= cfg_wdata[CountW-1:0];
        CFG_ZERO_OFFSET:   offset_r    <= cfg_wdata;
        default:           ;
      endcase
    end
  end

  always_comb begin
    shift_new    = {shift_r[SampleW-NibW-1:0], nibble_of(in_rx_byte)};
    is_probe     = !in_mode;
    reading_done = is_probe ? in_rx_byte[0] : (left_r == LeftW'(1));
    reading      = is_probe ? '0 : {{(SumW-SampleW){shift_new[SampleW-1]}}, shift_new};
    sum_add      = sum_r + reading;
    sum_mag      = sum_add[SumW-1] ? (~sum_add + 1'b1) : sum_add;
    n            = done_r + 1'b1;
    target       = (avg_count_r == '0) ? CountW'(1) : avg_count_r;
    mean_due     = reading_done && !(n < target);
  end

  assign status.mean_due = mean_due;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      shift_r <= '0;
      left_r  <= '0;
      done_r  <= '0;
      sum_r   <= '0;
    end else if (cmd.accept) begin
      if (is_probe) begin
        shift_r <= '0;
        left_r  <= in_rx_byte[0] ? '0 : LeftW'(DataBytes);
      end else if (left_r != '0) begin
        shift_r <= shift_new;
        left_r  <= left_r - 1'b1;
      end
      if (reading_done) begin
        if (mean_due) begin
          sum_r  <= '0;
          done_r <= '0;
        end else begin
          sum_r  <= sum_add;
          done_r <= n;
        end
      end
    end
  end

  // restoring divider, one quotient bit per step
  always_comb begin
    trial = {1'b0, rem_r, dq_r[MagW-1]} - {2'b00, div_n_r};
    fits  = !trial[CountW+1];
    quo   = dq_r[SampleW-1:0];
    mean  = neg_r ? (~quo + 1'b1) : quo;
  end

  always_ff @(posedge clk) begin
    if (cmd.div_load) begin
      neg_r   <= sum_add[SumW-1];
      dq_r    <= sum_mag[MagW-1:0];
      rem_r   <= '0;
      div_n_r <= n;
    end else if (cmd.div_step) begin
      rem_r <= fits ? trial[CountW-1:0] : {rem_r[CountW-2:0], dq_r[MagW-1]};
      dq_r  <= {dq_r[MagW-2:0], fits};
    end
    if (cmd.out_load) begin
      avg_r <= mean;
      net_r <= {mean[SampleW-1], mean} - {offset_r[SampleW-1], offset_r};
    end
  end

  assign out_average_raw = avg_r;
  assign out_net_value   = net_r;

endmodule

// ===== hw/rtl/load_cell_adc_sample_averager.sv =====
// Load-cell converter readout with averaging and tare. Bytes come in one per
// transaction: a probe byte (mode 0) starts a reading, and unless its bit 0 is
// set (reading taken as zero) six data bytes (mode 1) follow, each giving one
// nibble from bits 6,4,2,0. Readings are summed until average_count of them are
// in; then the truncated mean and the mean minus zero_offset go out as one
// transaction. A byte that does not finish a mean leaves the block ready for the
// next byte. A byte that finishes a mean holds off the next byte while the block
// loads the divider, runs the 31 steps of the restoring divider (one quotient
// bit a cycle) and loads the output register, plus any wait while it is full.
// Configuration writes take effect at once and belong in idle periods only.
module load_cell_adc_sample_averager (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_we,
  input  lcavg_pkg::cfg_idx_t                  cfg_index,
  input  logic [lcavg_pkg::SampleW-1:0]        cfg_wdata,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic                                 in_mode,
  input  logic [7:0]                           in_rx_byte,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [lcavg_pkg::SampleW-1:0] out_average_raw,
  output logic signed [lcavg_pkg::NetW-1:0]    out_net_value
);
  import lcavg_pkg::*;

  ctrl_cmd_t   cmd;
  dp_status_t  status;

  lcavg_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  lcavg_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .in_mode         (in_mode),
    .in_rx_byte      (in_rx_byte),
    .cmd             (cmd),
    .status          (status),
    .out_average_raw (out_average_raw),
    .out_net_value   (out_net_value)
  );

endmodule

// ===== hw/rtl/lcavg_chk.sv =====
module lcavg_chk (
  input logic                                 clk,
  input logic                                 rst_n,
  input logic                                 in_valid,
  input logic                                 in_ready,
  input logic                                 in_mode,
  input logic [7:0]                           in_rx_byte,
  input logic                                 out_valid,
  input logic                                 out_ready,
  input logic signed [lcavg_pkg::SampleW-1:0] out_average_raw,
  input logic signed [lcavg_pkg::NetW-1:0]    out_net_value
);

  // output register empties on reset
  a_reset_clears_out: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("out_valid set after reset");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_average_raw)
      && $stable(out_net_value))
    else $error("stalled result changed");

  // a new result only appears after the divider has held off input
  a_result_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> !$past(in_ready))
    else $error("result appeared without a busy cycle");

  // an accepted probe that starts a reading never produces a result right away
  a_probe_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && !in_mode && !in_rx_byte[0] |=> !$rose(out_valid))
    else $error("probe byte produced a result");

endmodule

bind load_cell_adc_sample_averager lcavg_chk u_lcavg_chk (.*);
